### src/trsp_pkg.sv
// trsp_pkg: shared constants and types for the timed release sorted pool
// depends on nothing
package trsp_pkg;
    localparam int unsigned PoolDepthDefault = 256;
    localparam int unsigned FieldW = 31;

    localparam logic [1:0] ModeAdd    = 2'd0;
    localparam logic [1:0] ModeGet    = 2'd1;
    localparam logic [1:0] ModeClear  = 2'd2;
    localparam logic [1:0] ModeUnused = 2'd3;

    localparam logic [2:0] StNone     = 3'd0;
    localparam logic [2:0] StReleased = 3'd1;
    localparam logic [2:0] StAdded    = 3'd2;
    localparam logic [2:0] StFull     = 3'd3;
    localparam logic [2:0] StCleared  = 3'd4;

    typedef struct packed {
        logic [FieldW-1:0] number;
        logic [FieldW-1:0] start;
        logic [FieldW-1:0] appear;
    } t_entry;
endpackage

### src/trsp_cmp.sv
// trsp_cmp: ordering compare of two pool entries, the shared compare unit
// depends on trsp_pkg
module trsp_cmp (
    input  logic            i_by_appear,
    input  trsp_pkg::t_entry i_cand,
    input  trsp_pkg::t_entry i_best,
    output logic            o_less
);
    logic [trsp_pkg::FieldW-1:0] w_kc;
    logic [trsp_pkg::FieldW-1:0] w_kb;
    assign w_kc = i_by_appear ? i_cand.appear : i_cand.start;
    assign w_kb = i_by_appear ? i_best.appear : i_best.start;
    assign o_less = (w_kc < w_kb) || ((w_kc == w_kb) && (i_cand.number < i_best.number));
endmodule

### src/timed_release_sorted_pool_top.sv
// timed_release_sorted_pool_top: top level, sequencer and slot memory
// depends on trsp_pkg and trsp_cmp
//
// bounded pool of timed entries. a transfer with mode add appends an entry
// (status added, or full once POOL_DEPTH slots are used since the last clear,
// sort or exhausted get), mode clear empties it, mode get releases the head if
// its appear time is at or before now_time. a get on an unsorted pool first
// runs a selection sort of the remaining entries through one shared compare
// unit, with one memory read per candidate for each scan slot. the slot memory
// has one read and one write port. one item is in work at a time: the input
// stall is high while an item is in work or a result waits.
module timed_release_sorted_pool_top #(
    parameter int unsigned POOL_DEPTH = trsp_pkg::PoolDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [30:0] i_entry_number,
    input  logic [30:0] i_entry_start,
    input  logic [30:0] i_entry_appear,
    input  logic [30:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [30:0] o_out_number,
    output logic [30:0] o_out_start,
    output logic [30:0] o_out_appear
);
    localparam int unsigned AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HREAD = 4'd1;  // read head, decided after wait
    localparam logic [3:0] S_HWAIT = 4'd2;
    localparam logic [3:0] S_HDEC  = 4'd3;
    localparam logic [3:0] S_SRD   = 4'd4;  // read scan slot as initial best
    localparam logic [3:0] S_SWT   = 4'd5;
    localparam logic [3:0] S_JRD   = 4'd6;  // candidate read loop
    localparam logic [3:0] S_WPICK = 4'd7;  // write scan entry into pick slot
    localparam logic [3:0] S_WFRNT = 4'd8;  // write best into front slot
    localparam logic [3:0] S_LRD   = 4'd9;  // last slot move
    localparam logic [3:0] S_LWT   = 4'd10;
    localparam logic [3:0] S_LWR   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_SWT_J = 4'd13;  // candidate read wait

    trsp_pkg::t_entry r_mem [POOL_DEPTH];
    trsp_pkg::t_entry r_rdata;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_head, n_head;
    logic          r_in_order, n_in_order;
    logic          r_by_appear;
    logic [30:0]   r_now, n_now;
    logic [CW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_front, n_front;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_pick, n_pick;
    logic          r_jpend, n_jpend;  // a candidate read is in flight
    logic [CW-1:0] r_jlast, n_jlast;  // index of the in-flight candidate
    trsp_pkg::t_entry r_best, n_best;
    trsp_pkg::t_entry r_scan_e, n_scan_e;
    trsp_pkg::t_entry r_oe, n_oe;
    logic [2:0]    r_ost, n_ost;
    logic          r_ovalid, n_ovalid;

    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    trsp_pkg::t_entry w_wdata;
    logic          w_less;

    trsp_cmp u_cmp (
        .i_by_appear (r_by_appear),
        .i_cand      (r_rdata),
        .i_best      (r_best),
        .o_less      (w_less)
    );

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_stall      = (r_state != S_IDLE) || r_ovalid;
    assign o_valid      = r_ovalid;
    assign o_status     = r_ost;
    assign o_out_number = r_oe.number;
    assign o_out_start  = r_oe.start;
    assign o_out_appear = r_oe.appear;

    always_comb begin
        n_state = r_state;  n_fill = r_fill;  n_head = r_head;
        n_in_order = r_in_order;  n_now = r_now;  n_scan = r_scan;
        n_front = r_front;  n_j = r_j;  n_pick = r_pick;  n_best = r_best;
        n_scan_e = r_scan_e;  n_oe = r_oe;  n_ost = r_ost;
        n_jpend = 1'b0;  n_jlast = r_jlast;
        n_ovalid = r_ovalid && i_stall;
        w_re = 1'b0;  w_raddr = '0;  w_we = 1'b0;  w_waddr = '0;
        w_wdata = r_scan_e;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_oe = '0;
                    n_ost = trsp_pkg::StNone;
                    n_now = i_now_time;
                    n_state = S_OUT;
                    unique case (i_mode)
                        trsp_pkg::ModeAdd: begin
                            if (r_fill < CW'(POOL_DEPTH)) begin
                                w_we = 1'b1;
                                w_waddr = r_fill[AW-1:0];
                                w_wdata.number = i_entry_number;
                                w_wdata.start = i_entry_start;
                                w_wdata.appear = i_entry_appear;
                                n_fill = r_fill + 1'b1;
                                if (r_fill != '0) n_in_order = 1'b0;
                                n_ost = trsp_pkg::StAdded;
                            end else begin
                                n_ost = trsp_pkg::StFull;
                            end
                        end
                        trsp_pkg::ModeGet: begin
                            if (r_fill == '0) begin
                                n_state = S_OUT;
                            end else if (r_head >= r_fill) begin
                                n_head = '0;  n_fill = '0;  n_in_order = 1'b1;
                            end else if (r_in_order || r_fill == CW'(1)) begin
                                n_in_order = 1'b1;
                                n_state = S_HREAD;
                            end else begin
                                n_scan = r_head;
                                n_front = '0;
                                n_state = S_SRD;
                            end
                        end
                        trsp_pkg::ModeClear: begin
                            n_fill = '0;  n_head = '0;  n_in_order = 1'b1;
                            n_ost = trsp_pkg::StCleared;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_HREAD: begin
                w_re = 1'b1;  w_raddr = r_head[AW-1:0];
                n_state = S_HWAIT;
            end
            S_HWAIT: n_state = S_HDEC;
            S_HDEC: begin
                if (r_rdata.appear <= r_now) begin
                    n_ost = trsp_pkg::StReleased;
                    n_oe = r_rdata;
                    n_head = r_head + 1'b1;
                end
                n_state = S_OUT;
            end
            S_SRD: begin
                n_j = r_scan;
                if (r_scan + 1'b1 < r_fill) begin
                    w_re = 1'b1;  w_raddr = r_scan[AW-1:0];
                    n_state = S_SWT;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_SWT: n_state = S_JRD;
            S_JRD: begin
                // first cycle here: rdata holds the scan entry
                if (r_j == r_scan) begin
                    n_best = r_rdata;
                    n_scan_e = r_rdata;
                    n_pick = r_scan;
                end else if (r_jpend && w_less) begin
                    n_best = r_rdata;
                    n_pick = r_jlast;
                end
                if (r_j + 1'b1 < r_fill) begin
                    w_re = 1'b1;  w_raddr = AW'(r_j + 1'b1);
                    n_jpend = 1'b1;  n_jlast = r_j + 1'b1;
                    n_j = r_j + 1'b1;
                    n_state = S_SWT_J;
                end else begin
                    n_state = S_WPICK;
                end
            end
            S_SWT_J: begin
                n_jpend = r_jpend;
                n_state = S_JRD;
            end
            S_WPICK: begin
                w_we = 1'b1;  w_waddr = r_pick[AW-1:0];  w_wdata = r_scan_e;
                n_state = S_WFRNT;
            end
            S_WFRNT: begin
                w_we = 1'b1;  w_waddr = r_front[AW-1:0];  w_wdata = r_best;
                n_front = r_front + 1'b1;
                n_scan = r_scan + 1'b1;
                n_j = r_scan + 1'b1;
                n_state = S_SRD;
            end
            S_LRD: begin
                w_re = 1'b1;  w_raddr = r_scan[AW-1:0];
                n_state = S_LWT;
            end
            S_LWT: n_state = S_LWR;
            S_LWR: begin
                w_we = 1'b1;  w_waddr = r_front[AW-1:0];  w_wdata = r_rdata;
                n_fill = r_front + 1'b1;
                n_head = '0;
                n_in_order = 1'b1;
                n_state = S_HREAD;
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;  r_fill <= '0;  r_head <= '0;
            r_in_order <= 1'b1;  r_by_appear <= 1'b0;  r_ovalid <= 1'b0;
            r_jpend <= 1'b0;
        end else begin
            r_state <= n_state;  r_fill <= n_fill;  r_head <= n_head;
            r_in_order <= n_in_order;  r_ovalid <= n_ovalid;  r_jpend <= n_jpend;
            if (i_cfg_we) r_by_appear <= i_cfg_data;
        end
        r_now <= n_now;  r_scan <= n_scan;  r_front <= n_front;
        r_j <= n_j;
        r_pick <= n_pick;  r_best <= n_best;  r_scan_e <= n_scan_e;
        r_jlast <= n_jlast;  r_oe <= n_oe;  r_ost <= n_ost;
    end
endmodule

### verif/trsp_result_checker.sv
// trsp_result_checker: watches both channels of the timed release sorted pool,
// predicts each result and compares it field by field
// depends on trsp_pkg
module trsp_result_checker #(
    parameter int unsigned POOL_DEPTH = trsp_pkg::PoolDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [30:0] i_entry_number,
    input  logic [30:0] i_entry_start,
    input  logic [30:0] i_entry_appear,
    input  logic [30:0] i_now_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [30:0] i_out_number,
    input  logic [30:0] i_out_start,
    input  logic [30:0] i_out_appear,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [2:0]       status;
        trsp_pkg::t_entry entry;
    } t_release;

    trsp_pkg::t_entry pool [POOL_DEPTH];
    int       fill_count;
    int       head_pos;
    logic     in_order;
    logic     by_appear;
    t_release release_q[$];

    function automatic logic [30:0] sort_key(int idx);
        return by_appear ? pool[idx].appear : pool[idx].start;
    endfunction

    // selection sort of the unreleased entries, compacted to the front
    task automatic sort_pool();
        int          scan;
        int          front;
        int          pick;
        logic [30:0] best;
        logic [30:0] k;
        trsp_pkg::t_entry tmp;
        scan  = head_pos;
        front = 0;
        for (; scan + 1 < fill_count; scan++) begin
            pick = scan;
            best = sort_key(scan);
            for (int j = scan + 1; j < fill_count; j++) begin
                k = sort_key(j);
                if (k < best || (k == best && pool[j].number < pool[pick].number)) begin
                    pick = j;
                    best = k;
                end
            end
            tmp          = pool[pick];
            pool[pick]   = pool[scan];
            pool[front]  = tmp;
            front++;
        end
        pool[front] = pool[scan];
        front++;
        in_order   = 1'b1;
        fill_count = front;
        head_pos   = 0;
    endtask

    task automatic predict_release(logic [1:0] mode, trsp_pkg::t_entry e,
                                   logic [30:0] now);
        t_release r;
        r = '0;
        case (mode)
            trsp_pkg::ModeAdd: begin
                if (fill_count < POOL_DEPTH) begin
                    pool[fill_count] = e;
                    fill_count++;
                    if (fill_count > 1) in_order = 1'b0;
                    r.status = trsp_pkg::StAdded;
                end else begin
                    r.status = trsp_pkg::StFull;
                end
            end
            trsp_pkg::ModeGet: begin
                if (fill_count == 0) begin
                    r.status = trsp_pkg::StNone;
                end else if (head_pos >= fill_count) begin
                    // exhausted pool resets its counters
                    head_pos   = 0;
                    fill_count = 0;
                    in_order   = 1'b1;
                end else begin
                    if (fill_count == 1) in_order = 1'b1;
                    if (!in_order) sort_pool();
                    if (head_pos < fill_count && pool[head_pos].appear <= now) begin
                        r.status = trsp_pkg::StReleased;
                        r.entry  = pool[head_pos];
                        head_pos++;
                    end
                end
            end
            trsp_pkg::ModeClear: begin
                fill_count = 0;
                head_pos   = 0;
                in_order   = 1'b1;
                r.status   = trsp_pkg::StCleared;
            end
            default: r.status = trsp_pkg::StNone;
        endcase
        release_q.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_release exp_r;
        t_release got;
        if (!i_rst_n) begin
            fill_count = 0;
            head_pos   = 0;
            in_order   = 1'b1;
            by_appear  = 1'b0;
            release_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) by_appear = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = {i_status, i_out_number, i_out_start, i_out_appear};
                if (release_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: status %0d number %0h", i_status,
                                 i_out_number);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_r = release_q.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: exp status %0d num %0h start %0h appear %0h",
                                     exp_r.status, exp_r.entry.number, exp_r.entry.start,
                                     exp_r.entry.appear);
                            $display("          got status %0d num %0h start %0h appear %0h",
                                     got.status, got.entry.number, got.entry.start,
                                     got.entry.appear);
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_in_stall)
                predict_release(i_mode, {i_entry_number, i_entry_start, i_entry_appear},
                                i_now_time);
        end
        o_pending = release_q.size();
    end
endmodule

### verif/tb_timed_release_sorted_pool_top.sv
// tb_timed_release_sorted_pool_top: stimulus and verdict for the pool
// depends on trsp_pkg, trsp_result_checker and timed_release_sorted_pool_top
module tb_timed_release_sorted_pool_top;
    localparam int NumItems    = 1850;
    localparam int CalmFrom    = 1650;   // no idling from here on
    localparam int LongHoldCyc = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [30:0] i_entry_number;
    logic [30:0] i_entry_start;
    logic [30:0] i_entry_appear;
    logic [30:0] i_now_time;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [30:0] o_out_number;
    logic [30:0] o_out_start;
    logic [30:0] o_out_appear;

    int   fail_count;
    int   pending;
    int   sent;
    bit   idle_on;
    bit   long_hold;

    timed_release_sorted_pool_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_entry_number (i_entry_number),
        .i_entry_start  (i_entry_start),
        .i_entry_appear (i_entry_appear),
        .i_now_time     (i_now_time),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_number   (o_out_number),
        .o_out_start    (o_out_start),
        .o_out_appear   (o_out_appear)
    );

    trsp_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_entry_number (i_entry_number),
        .i_entry_start  (i_entry_start),
        .i_entry_appear (i_entry_appear),
        .i_now_time     (i_now_time),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_status       (o_status),
        .i_out_number   (o_out_number),
        .i_out_start    (o_out_start),
        .i_out_appear   (o_out_appear),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run (a few full-pool sorts)
    initial begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side: random stall bursts, plus one long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (LongHoldCyc) @(posedge i_clk);
                long_hold = 1'b0;
                i_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // time values: mostly small so keys tie and now straddles appear times,
    // sometimes full range so every bit toggles
    function automatic logic [30:0] rand_time();
        if ($urandom_range(0, 2) == 0) return 31'($urandom);
        return 31'($urandom_range(0, 15));
    endfunction

    // one transfer on the input channel, optionally after a random gap
    task automatic send(logic [1:0] mode, logic [30:0] num, logic [30:0] st,
                        logic [30:0] ap, logic [30:0] now);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= mode;
        i_entry_number <= num;
        i_entry_start  <= st;
        i_entry_appear <= ap;
        i_now_time     <= now;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic add_random();
        send(trsp_pkg::ModeAdd,
             31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 9)),
             rand_time(), rand_time(), 31'($urandom));
    endtask

    task automatic get_random();
        logic [30:0] now;
        now = ($urandom_range(0, 3) == 0) ? 31'h7fffffff : rand_time();
        send(trsp_pkg::ModeGet, 31'($urandom), 31'($urandom), 31'($urandom), now);
    endtask

    // register writes only once the block has drained
    task automatic write_mode(logic v);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int n;
        int phase;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= 1'b0;
        i_valid        <= 1'b0;
        i_mode         <= trsp_pkg::ModeAdd;
        i_entry_number <= '0;
        i_entry_start  <= '0;
        i_entry_appear <= '0;
        i_now_time     <= '0;
        sent      = 0;
        idle_on   = 1'b1;
        long_hold = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty get, field extremes, ties, gating, exhaustion, noise
        write_mode(1'b0);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7fffffff);
        send(trsp_pkg::ModeAdd, 31'h7fffffff, 31'h7fffffff, '0, '0);
        send(trsp_pkg::ModeAdd, '0, '0, 31'h7fffffff, '0);
        send(trsp_pkg::ModeAdd, 31'd5, 31'd3, 31'd1, '0);
        send(trsp_pkg::ModeAdd, 31'd4, 31'd3, 31'd1, '0);
        send(trsp_pkg::ModeGet, '0, '0, '0, '0);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'd1);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'd1);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7ffffffe);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7fffffff);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7fffffff);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7fffffff);
        send(trsp_pkg::ModeAdd, 31'd9, 31'd20, 31'd30, '0);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'd29);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'd30);
        send(trsp_pkg::ModeUnused, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
             31'h7fffffff);
        write_mode(1'b1);
        send(trsp_pkg::ModeAdd, 31'd1, 31'd0, 31'd8, '0);
        send(trsp_pkg::ModeAdd, 31'd2, 31'd9, 31'd2, '0);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'd7);
        send(trsp_pkg::ModeClear, '0, '0, '0, '0);
        send(trsp_pkg::ModeGet, '0, '0, '0, 31'h7fffffff);

        // random phases of adds, gets, clears and unused-mode transfers; two fill the pool completely
        phase = 0;
        while (sent < NumItems) begin
            if (sent >= CalmFrom) idle_on = 1'b0;
            if ($urandom_range(0, 4) == 0) write_mode(1'($urandom));
            if (phase == 6) long_hold = 1'b1;
            n = (phase == 3 || phase == 40) ? 257 : $urandom_range(0, 12);
            for (int k = 0; k < n; k++) begin
                add_random();
                if (n < 20 && $urandom_range(0, 5) == 0) get_random();
            end
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 19))
                    0:       send(trsp_pkg::ModeClear, 31'($urandom), 31'($urandom),
                                  31'($urandom), 31'($urandom));
                    1:       send(trsp_pkg::ModeUnused, 31'($urandom), 31'($urandom),
                                  31'($urandom), 31'($urandom));
                    2, 3:    add_random();
                    default: get_random();
                endcase
            end
            phase++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### timed_release_sorted_pool_top.f
src/trsp_pkg.sv
src/trsp_cmp.sv
src/timed_release_sorted_pool_top.sv
verif/trsp_result_checker.sv
verif/tb_timed_release_sorted_pool_top.sv
